[hw/rtl/rtpf_pkg.sv]
// Shared types and constants of the two-plane pixel fill engine.
// No dependencies; every other file of the block imports this package.
package rtpf_pkg;

  localparam int DEF_PANEL_WIDTH  = 880;
  localparam int DEF_PANEL_HEIGHT = 528;
  localparam int DEF_QUEUE_DEPTH  = 2;

  // Coordinates after clamping always fit the largest panel side (4096).
  localparam int COORD_W = 12;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_CAP = 20'd524288;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_FILL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    COL_BLACK = 2'd0,
    COL_RED   = 2'd1,
    COL_WHITE = 2'd2,
    COL_KEEP  = 2'd3
  } colour_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    JOB_NONE   = 2'd0,
    JOB_PIXELS = 2'd1,
    JOB_CLEAR  = 2'd2,
    JOB_READ   = 2'd3
  } job_kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_RD,
    ST_WR,
    ST_RDATA,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] x_first;
    logic [15:0] y_first;
    logic [15:0] x_last;
    logic [15:0] y_last;
    colour_e     colour;
    logic [15:0] byte_address;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         black_byte;
    logic [7:0]         red_byte;
    logic [COUNT_W-1:0] pixels_written;
  } res_t;

  // Classified command, as queued between front and back.
  typedef struct packed {
    job_kind_e          kind;
    colour_e            colour;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] x_last;
    logic [COORD_W-1:0] y_last;
    logic [15:0]        byte_address;
  } job_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

endpackage

[hw/rtl/rtpf_if.sv]
// Valid/ready channels of the pixel fill engine: command word in, result word out.
// Depends on rtpf_pkg for the payload structs.
interface rtpf_cmd_if;
  import rtpf_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rtpf_res_if;
  import rtpf_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/rtpf_front.sv]
// Front end: accepts command words, clamps rectangles to the rotated panel
// and classifies them into jobs for the queue. Depends on rtpf_pkg, rtpf_if.
module rtpf_front #(
  parameter int PANEL_WIDTH  = rtpf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rtpf_pkg::DEF_PANEL_HEIGHT
) (
  rtpf_cmd_if.sink        cmd_i,
  input  rtpf_pkg::rot_e  rotation_i,
  input  logic            q_full_i,
  input  logic            init_busy_i,
  output logic            push_o,
  output rtpf_pkg::job_t  job_o
);
  import rtpf_pkg::*;

  localparam logic [15:0] W_M1 = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] H_M1 = 16'(PANEL_HEIGHT - 1);

  logic        swap;
  logic [15:0] lim_x, lim_y;
  logic [15:0] xe_in, ye_in;
  logic [15:0] xe_c, ye_c;
  logic        empty;

  assign cmd_i.ready = !q_full_i && !init_busy_i;
  assign push_o      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    swap  = (rotation_i == ROT_90) || (rotation_i == ROT_270);
    lim_x = swap ? H_M1 : W_M1;
    lim_y = swap ? W_M1 : H_M1;
    xe_in = (cmd_i.data.opcode == OP_FILL) ? cmd_i.data.x_last : cmd_i.data.x_first;
    ye_in = (cmd_i.data.opcode == OP_FILL) ? cmd_i.data.y_last : cmd_i.data.y_first;
    xe_c  = (xe_in > lim_x) ? lim_x : xe_in;
    ye_c  = (ye_in > lim_y) ? lim_y : ye_in;
    empty = (cmd_i.data.x_first > xe_c) || (cmd_i.data.y_first > ye_c);
  end

  always_comb begin
    job_o.colour       = cmd_i.data.colour;
    job_o.x_first      = COORD_W'(cmd_i.data.x_first);
    job_o.y_first      = COORD_W'(cmd_i.data.y_first);
    job_o.x_last       = COORD_W'(xe_c);
    job_o.y_last       = COORD_W'(ye_c);
    job_o.byte_address = cmd_i.data.byte_address;
    unique case (cmd_i.data.opcode)
      OP_READ:  job_o.kind = JOB_READ;
      OP_CLEAR: job_o.kind = (cmd_i.data.colour == COL_KEEP) ? JOB_NONE : JOB_CLEAR;
      default: begin
        // plot is a one-pixel fill
        job_o.kind = (cmd_i.data.colour == COL_KEEP || empty) ? JOB_NONE : JOB_PIXELS;
      end
    endcase
  end

endmodule

[hw/rtl/rtpf_queue.sv]
// Short job queue between the front end and the plane engine.
// Depends on rtpf_pkg for the job struct.
module rtpf_queue #(
  parameter int DEPTH = rtpf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rtpf_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output rtpf_pkg::job_t job_o
);
  import rtpf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign job_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

[hw/rtl/rtpf_back.sv]
// Plane engine: holds both bit planes, runs the reset clearing pass, the
// per-pixel read-modify-write walk, plane clears and byte reads, and the
// result register. Depends on rtpf_pkg and rtpf_if.
module rtpf_back #(
  parameter int PANEL_WIDTH  = rtpf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rtpf_pkg::DEF_PANEL_HEIGHT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtpf_pkg::rot_e rotation_i,
  input  logic           job_valid_i,
  input  rtpf_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           init_busy_o,
  rtpf_res_if.source     res_o
);
  import rtpf_pkg::*;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int PLANE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
  localparam int PIX_TOTAL   = PANEL_WIDTH * PANEL_HEIGHT;

  localparam logic [ADDR_W-1:0]  ROW_BYTES_A = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(PLANE_BYTES - 1);
  localparam logic [COORD_W-1:0] W_M1        = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] H_M1        = COORD_W'(PANEL_HEIGHT - 1);
  localparam logic [COUNT_W-1:0] CLEAR_COUNT =
      (PIX_TOTAL > int'(COUNT_CAP)) ? COUNT_CAP : COUNT_W'(PIX_TOTAL);

  function automatic coord_t rotate(input rot_e rot, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
    coord_t r;
    case (rot)
      ROT_0: begin
        r.x = x;
        r.y = y;
      end
      ROT_90: begin
        r.x = W_M1 - y;
        r.y = x;
      end
      ROT_180: begin
        r.x = W_M1 - x;
        r.y = H_M1 - y;
      end
      default: begin
        r.x = y;
        r.y = H_M1 - x;
      end
    endcase
    return r;
  endfunction

  logic [7:0] black_mem [PLANE_BYTES];
  logic [7:0] red_mem   [PLANE_BYTES];

  back_state_e state_q, state_d;

  // walk state, unrotated except pos_q
  logic [COORD_W-1:0] x_q, y_q, xs_q, xe_q, ye_q;
  logic [COORD_W-1:0] x_nx, y_nx;
  coord_t             pos_q;
  colour_e            colour_q;
  logic [ADDR_W-1:0]  waddr_q;
  logic [7:0]         mask_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic [7:0]         fill_black_q, fill_red_q;
  logic               rd_ok_q;
  logic [7:0]         rd_black_q, rd_red_q;
  logic [7:0]         acc_black_q, acc_red_q;
  logic [COUNT_W-1:0] acc_cnt_q;
  logic               res_valid_q;
  res_t               res_q;

  logic              pop;
  logic              rd_en, wr_en, load_res;
  logic [ADDR_W-1:0] rd_addr, wr_addr, pix_addr;
  logic [7:0]        pix_mask, wr_black, wr_red;
  logic              sweep_last, walk_end, out_free;

  assign pix_addr   = ADDR_W'(pos_q.x >> 3) + ADDR_W'(pos_q.y) * ROW_BYTES_A;
  assign pix_mask   = 8'h80 >> pos_q.x[2:0];
  assign sweep_last = (sweep_q == LAST_ADDR);
  assign walk_end   = (x_q == xe_q) && (y_q == ye_q);
  assign out_free   = !res_valid_q || res_o.ready;
  assign x_nx       = (x_q == xe_q) ? xs_q : x_q + 1'b1;
  assign y_nx       = (x_q == xe_q) ? y_q + 1'b1 : y_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:  if (sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.kind)
            JOB_PIXELS: state_d = ST_RD;
            JOB_CLEAR:  state_d = ST_SWEEP;
            JOB_READ:   state_d = ST_RDATA;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: if (sweep_last) state_d = ST_DONE;
      ST_RD:    state_d = ST_WR;
      ST_WR:    state_d = walk_end ? ST_DONE : ST_RD;
      ST_RDATA: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = (state_q == ST_IDLE) && job_valid_i;
    rd_en    = (pop && job_i.kind == JOB_READ) || (state_q == ST_RD);
    rd_addr  = (state_q == ST_RD) ? pix_addr : ADDR_W'(job_i.byte_address);
    wr_en    = (state_q == ST_INIT) || (state_q == ST_SWEEP) || (state_q == ST_WR);
    wr_addr  = (state_q == ST_WR) ? waddr_q : sweep_q;
    load_res = (state_q == ST_DONE) && out_free;
    if (state_q == ST_WR) begin
      wr_black = (colour_q == COL_BLACK) ? (rd_black_q & ~mask_q) : (rd_black_q | mask_q);
      wr_red   = (colour_q == COL_RED)   ? (rd_red_q & ~mask_q)   : (rd_red_q | mask_q);
    end else begin
      wr_black = fill_black_q;
      wr_red   = fill_red_q;
    end
  end

  assign job_pop_o   = pop;
  assign init_busy_o = (state_q == ST_INIT);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      sweep_q      <= '0;
      fill_black_q <= 8'hFF;
      fill_red_q   <= 8'hFF;
      res_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT || state_q == ST_SWEEP) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
      if (pop && job_i.kind == JOB_CLEAR) begin
        fill_black_q <= (job_i.colour == COL_BLACK) ? 8'h00 : 8'hFF;
        fill_red_q   <= (job_i.colour == COL_RED)   ? 8'h00 : 8'hFF;
      end
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      x_q         <= job_i.x_first;
      y_q         <= job_i.y_first;
      xs_q        <= job_i.x_first;
      xe_q        <= job_i.x_last;
      ye_q        <= job_i.y_last;
      pos_q       <= rotate(rotation_i, job_i.x_first, job_i.y_first);
      colour_q    <= job_i.colour;
      rd_ok_q     <= 32'(job_i.byte_address) < 32'(PLANE_BYTES);
      acc_black_q <= '0;
      acc_red_q   <= '0;
      acc_cnt_q   <= (job_i.kind == JOB_CLEAR) ? CLEAR_COUNT : '0;
    end
    if (state_q == ST_RD) begin
      waddr_q <= pix_addr;
      mask_q  <= pix_mask;
    end
    if (state_q == ST_WR) begin
      if (acc_cnt_q != COUNT_CAP) begin
        acc_cnt_q <= acc_cnt_q + 1'b1;
      end
      if (!walk_end) begin
        x_q   <= x_nx;
        y_q   <= y_nx;
        pos_q <= rotate(rotation_i, x_nx, y_nx);
      end
    end
    if (state_q == ST_RDATA) begin
      acc_black_q <= rd_ok_q ? rd_black_q : '0;
      acc_red_q   <= rd_ok_q ? rd_red_q : '0;
    end
    if (load_res) begin
      res_q.black_byte     <= acc_black_q;
      res_q.red_byte       <= acc_red_q;
      res_q.pixels_written <= acc_cnt_q;
    end
  end

  // plane memories: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      black_mem[wr_addr] <= wr_black;
      red_mem[wr_addr]   <= wr_red;
    end
    if (rd_en) begin
      rd_black_q <= black_mem[rd_addr];
      rd_red_q   <= red_mem[rd_addr];
    end
  end

  a_no_pop_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |-> !pop)
    else $error("job taken during clearing pass");

  a_rd_wr_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("plane read and write in one cycle");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |-> $past(state_q) == ST_RD)
    else $error("pixel write without preceding read");

  // the count register is loaded on every pop, so it is only meaningful once done
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> acc_cnt_q <= COUNT_CAP)
    else $error("pixel count beyond saturation");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |=> res_valid_q && $stable(res_q))
    else $error("stalled result word changed");

endmodule

[hw/rtl/rotated_two_plane_pixel_fill_top.sv]
// Per job: plot and fill read, then write the byte of each covered pixel; clear
// sweeps all PLANE_BYTES bytes; read fetches one byte. All are limited by the
// single plane memory port. Jobs pass the registered job queue; results are word-registered.
// After reset a clearing pass writes white to all ceil(W/8)*H bytes while no
// command word is accepted; rotation writes are taken.
// Depends on rtpf_pkg, rtpf_if, rtpf_front, rtpf_queue, rtpf_back.
module rotated_two_plane_pixel_fill_top #(
  parameter int PANEL_WIDTH  = rtpf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rtpf_pkg::DEF_PANEL_HEIGHT,
  parameter int QUEUE_DEPTH  = rtpf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rotation_we_i,
  input  logic [1:0] rotation_i,
  rtpf_cmd_if.sink   cmd_i,
  rtpf_res_if.source res_o
);
  import rtpf_pkg::*;

  rot_e rotation_q;
  logic push, q_full, q_valid, pop, init_busy;
  job_t front_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (rotation_we_i) begin
      rotation_q <= rot_e'(rotation_i);
    end
  end

  rtpf_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .cmd_i      (cmd_i),
    .rotation_i (rotation_q),
    .q_full_i   (q_full),
    .init_busy_i(init_busy),
    .push_o     (push),
    .job_o      (front_job)
  );

  rtpf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .job_o  (head_job)
  );

  rtpf_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rotation_i (rotation_q),
    .job_valid_i(q_valid),
    .job_i      (head_job),
    .job_pop_o  (pop),
    .init_busy_o(init_busy),
    .res_o      (res_o)
  );

endmodule
